// ----- rtl/sm3_pkg.sv -----
// Shared types, constants and bit functions of the SM3 hash engine.
`default_nettype none
package sm3_pkg;

	typedef logic [31:0] word_t;
	typedef logic [0:7][31:0] state8_t;

	localparam word_t SM3_T_LOW  = 32'h79CC4519;
	localparam word_t SM3_T_HIGH = 32'h7A879D8A;
	localparam word_t PAD_WORD   = 32'h80000000;

	localparam state8_t SM3_IV = '{
		32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
		32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
	};

	typedef struct packed {
		logic       load;
		logic       step;
		logic       fold;
		logic       reload;
		logic [5:0] rnd;
	} rnd_ctl_t;

	typedef struct packed {
		logic  push;
		logic  step;
		word_t word;
	} sch_ctl_t;

	function automatic word_t rol32(word_t x, logic [4:0] n);
		logic [63:0] dbl;
		dbl = {x, x} << n;
		return dbl[63:32];
	endfunction

	function automatic word_t perm0(word_t x);
		return x ^ rol32(x, 5'd9) ^ rol32(x, 5'd17);
	endfunction

	function automatic word_t perm1(word_t x);
		return x ^ rol32(x, 5'd15) ^ rol32(x, 5'd23);
	endfunction

endpackage
`default_nettype wire

// ----- rtl/sm3_in_if.sv -----
// Message word channel: valid, ready and one message word with its byte count.
`default_nettype none
interface sm3_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] message_word;
	logic [2:0]  byte_count;
	logic        last_word;

	modport source (output valid, message_word, byte_count, last_word, input ready);
	modport sink (input valid, message_word, byte_count, last_word, output ready);
endinterface
`default_nettype wire

// ----- rtl/sm3_out_if.sv -----
// Digest word channel: valid, ready and one digest word with its position.
`default_nettype none
interface sm3_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        final_word;

	modport source (output valid, digest_word, word_index, final_word, input ready);
	modport sink (input valid, digest_word, word_index, final_word, output ready);
endinterface
`default_nettype wire

// ----- rtl/sm3_sched.sv -----
// Sixteen-word message window: loads block words and expands W on the fly.
`default_nettype none
module sm3_sched
	import sm3_pkg::*;
(
	input  wire logic     clk,
	input  wire sch_ctl_t ctl,
	output word_t         w_j,
	output word_t         w_j4
);

	word_t win_q [16];
	word_t w_new;

	always_comb begin
		w_new = perm1(win_q[0] ^ win_q[7] ^ rol32(win_q[13], 5'd15))
			^ rol32(win_q[3], 5'd7) ^ win_q[10];
	end

	always_ff @(posedge clk) begin
		if (ctl.push || ctl.step) begin
			for (int k = 0; k < 15; k++) begin
				win_q[k] <= win_q[k+1];
			end
			win_q[15] <= ctl.push ? ctl.word : w_new;
		end
	end

	assign w_j  = win_q[0];
	assign w_j4 = win_q[4];

endmodule
`default_nettype wire

// ----- rtl/sm3_round.sv -----
// Shared SM3 round unit with working registers A..H and the chaining value.
`default_nettype none
module sm3_round
	import sm3_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire rnd_ctl_t ctl,
	input  wire word_t    w_j,
	input  wire word_t    w_j4,
	output state8_t       chain
);

	state8_t chain_q;
	state8_t r_q;
	state8_t r_next;
	word_t   a12, tj, ss1, ss2, ff, gg, tt1, tt2;
	logic    early;

	always_comb begin
		early  = (ctl.rnd[5:4] == 2'd0);
		a12    = rol32(r_q[0], 5'd12);
		tj     = rol32(early ? SM3_T_LOW : SM3_T_HIGH, ctl.rnd[4:0]);
		ss1    = rol32(a12 + r_q[4] + tj, 5'd7);
		ss2    = ss1 ^ a12;
		if (early) begin
			ff = r_q[0] ^ r_q[1] ^ r_q[2];
			gg = r_q[4] ^ r_q[5] ^ r_q[6];
		end else begin
			ff = (r_q[0] & r_q[1]) | (r_q[0] & r_q[2]) | (r_q[1] & r_q[2]);
			gg = (r_q[4] & r_q[5]) | (~r_q[4] & r_q[6]);
		end
		tt1       = ff + r_q[3] + ss2 + (w_j ^ w_j4);
		tt2       = gg + r_q[7] + ss1 + w_j;
		r_next[0] = tt1;
		r_next[1] = r_q[0];
		r_next[2] = rol32(r_q[1], 5'd9);
		r_next[3] = r_q[2];
		r_next[4] = perm0(tt2);
		r_next[5] = r_q[4];
		r_next[6] = rol32(r_q[5], 5'd19);
		r_next[7] = r_q[6];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= SM3_IV;
			r_q     <= '0;
		end else begin
			if (ctl.reload) begin
				chain_q <= SM3_IV;
			end else if (ctl.fold) begin
				chain_q <= chain_q ^ r_q;
			end
			if (ctl.load) begin
				r_q <= chain_q;
			end else if (ctl.step) begin
				r_q <= r_next;
			end
		end
	end

	assign chain = chain_q;

endmodule
`default_nettype wire

// ----- rtl/sm3_hash_engine_core.sv -----
// SM3 hash engine top level: block loader, padding sequencer and digest output.
// Message words enter one per cycle while the block buffer fills; the sixteenth
// word of a block starts a compression on the single shared round unit, which
// runs one round per cycle for rounds 0 to 63 plus a feed-forward step; the
// input is not ready during compression. A word with last_word set is followed
// by one padding word per cycle outside compressions (0x80 marker word after a
// four-byte last word, else merged into it; zeros; bit length high then low),
// one or two compressions and eight digest transactions, A first; input stays
// not ready until the eighth digest word is taken, then the IV is reloaded.
`default_nettype none
module sm3_hash_engine_core
	import sm3_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	sm3_in_if.sink     msg_in,
	sm3_out_if.source  dig_out
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_FOLD,
		ST_EMIT
	} state_t;

	state_t      state_q;
	logic [3:0]  wc_q;
	logic [63:0] len_q;
	logic        pad_q;
	logic        need80_q;
	logic        hi_done_q;
	logic        fin_q;
	logic [5:0]  round_q;
	logic [2:0]  idx_q;

	rnd_ctl_t    rnd_ctl;
	sch_ctl_t    sch_ctl;
	word_t       w_j, w_j4;
	state8_t     chain;

	logic        in_acc, out_acc, push_v, blk_full;
	word_t       push_word, last_word_v;
	logic [2:0]  b_sat;
	logic [5:0]  len_add;

	assign in_acc  = msg_in.valid && msg_in.ready;
	assign out_acc = dig_out.valid && dig_out.ready;

	always_comb begin
		b_sat = (msg_in.byte_count > 3'd4) ? 3'd4 : msg_in.byte_count;
		case (b_sat[1:0])
			2'd0:    last_word_v = PAD_WORD;
			2'd1:    last_word_v = {msg_in.message_word[31:24], 24'h800000};
			2'd2:    last_word_v = {msg_in.message_word[31:16], 16'h8000};
			default: last_word_v = {msg_in.message_word[31:8], 8'h80};
		endcase
		if (!msg_in.last_word || b_sat[2]) begin
			last_word_v = msg_in.message_word;
		end
		len_add = msg_in.last_word ? {b_sat, 3'b000} : 6'd32;

		push_v    = 1'b0;
		push_word = last_word_v;
		if (state_q == ST_IDLE) begin
			push_v = in_acc;
		end else if (state_q == ST_PAD) begin
			push_v = 1'b1;
			if (need80_q) begin
				push_word = PAD_WORD;
			end else if (hi_done_q) begin
				push_word = len_q[31:0];
			end else if (wc_q == 4'd14) begin
				push_word = len_q[63:32];
			end else begin
				push_word = '0;
			end
		end
		blk_full = push_v && (wc_q == 4'd15);
	end

	always_comb begin
		sch_ctl.push   = push_v;
		sch_ctl.step   = (state_q == ST_ROUND);
		sch_ctl.word   = push_word;
		rnd_ctl.load   = blk_full;
		rnd_ctl.step   = (state_q == ST_ROUND);
		rnd_ctl.fold   = (state_q == ST_FOLD);
		rnd_ctl.reload = out_acc && (idx_q == 3'd7);
		rnd_ctl.rnd    = round_q;
	end

	sm3_sched u_sched (
		.clk  (clk),
		.ctl  (sch_ctl),
		.w_j  (w_j),
		.w_j4 (w_j4)
	);

	sm3_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (rnd_ctl),
		.w_j    (w_j),
		.w_j4   (w_j4),
		.chain  (chain)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			wc_q      <= '0;
			len_q     <= '0;
			pad_q     <= 1'b0;
			need80_q  <= 1'b0;
			hi_done_q <= 1'b0;
			fin_q     <= 1'b0;
			round_q   <= '0;
			idx_q     <= '0;
		end else begin
			if (push_v) begin
				wc_q <= wc_q + 4'd1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						len_q <= len_q + {58'd0, len_add};
						if (msg_in.last_word) begin
							pad_q     <= 1'b1;
							need80_q  <= b_sat[2];
							hi_done_q <= 1'b0;
							fin_q     <= 1'b0;
						end
						if (blk_full) begin
							state_q <= ST_ROUND;
							round_q <= '0;
						end else if (msg_in.last_word) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					if (need80_q) begin
						need80_q <= 1'b0;
					end else if (hi_done_q) begin
						fin_q <= 1'b1;
					end else if (wc_q == 4'd14) begin
						hi_done_q <= 1'b1;
					end
					if (blk_full) begin
						state_q <= ST_ROUND;
						round_q <= '0;
					end
				end
				ST_ROUND: begin
					round_q <= round_q + 6'd1;
					if (round_q == 6'd63) begin
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					if (fin_q) begin
						state_q <= ST_EMIT;
						idx_q   <= '0;
					end else if (pad_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_acc) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							state_q   <= ST_IDLE;
							pad_q     <= 1'b0;
							fin_q     <= 1'b0;
							hi_done_q <= 1'b0;
							len_q     <= '0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign msg_in.ready        = (state_q == ST_IDLE);
	assign dig_out.valid       = (state_q == ST_EMIT);
	assign dig_out.digest_word = chain[idx_q];
	assign dig_out.word_index  = idx_q;
	assign dig_out.final_word  = (idx_q == 3'd7);

	a_not_both: assert property (@(posedge clk) disable iff (!arst_n)
		!(msg_in.ready && dig_out.valid))
		else $error("input ready while digest is pending");

	a_round_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (wc_q == 4'd0))
		else $error("compression running on a partial block");

	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && round_q == 6'd63) |=> (state_q == ST_FOLD))
		else $error("compression did not end after round 63");

	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && dig_out.final_word) |=> (msg_in.ready && len_q == 64'd0))
		else $error("engine not restarted after final digest word");

	a_emit_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (fin_q && wc_q == 4'd0))
		else $error("digest emitted before padding completed");

endmodule
`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench of the SM3 hash engine: directed vectors, random messages, digest checks.
`default_nettype none
module tb;
	import sm3_pkg::*;

	localparam word_t ROUND_T_LO = 32'h79CC4519;
	localparam word_t ROUND_T_HI = 32'h7A879D8A;
	localparam state8_t CHAIN_INIT = {
		32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
		32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
	};
	localparam word_t MARKER_WORD = 32'h80000000;
	localparam int unsigned RANDOM_ITEMS = 200;
	localparam int unsigned QUIET_ITEMS = 165;
	localparam int unsigned DRAIN_CYCLES = 200;
	localparam int unsigned WATCHDOG_LIMIT = 2000;

	typedef struct {
		word_t      digest_word;
		logic [2:0] word_index;
		logic       final_word;
	} digest_exp_t;

	typedef struct {
		word_t      msg;
		logic [2:0] nbytes;
		logic       last;
		bit         known;
		state8_t    digest;
	} vector_row_t;

	logic clk;
	logic arst_n;

	sm3_in_if  msg_in ();
	sm3_out_if dig_out ();

	sm3_hash_engine_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.msg_in  (msg_in),
		.dig_out (dig_out)
	);

	state8_t      hash_chain;
	word_t        blk_buf [0:15];
	int unsigned  blk_fill;
	logic [63:0]  msg_bits;
	digest_exp_t  digest_q [$];
	vector_row_t  vector_tab [$];
	int unsigned  mismatches;
	bit           idle_on;
	bit           stall_on;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic word_t rotl(word_t x, int unsigned n);
		int unsigned s;
		s = n % 32;
		if (s == 0) begin
			return x;
		end
		return (x << s) | (x >> (32 - s));
	endfunction

	function automatic word_t mix0(word_t x);
		return x ^ rotl(x, 9) ^ rotl(x, 17);
	endfunction

	function automatic word_t mix1(word_t x);
		return x ^ rotl(x, 15) ^ rotl(x, 23);
	endfunction

	task automatic compress_block();
		word_t w [0:67];
		word_t a, b, c, d, e, f, g, h;
		word_t a12, ss1, ss2, tt1, tt2, ff, gg, tj;
		for (int j = 0; j < 16; j++) begin
			w[j] = blk_buf[j];
		end
		for (int j = 16; j < 68; j++) begin
			w[j] = mix1(w[j-16] ^ w[j-9] ^ rotl(w[j-3], 15)) ^ rotl(w[j-13], 7) ^ w[j-6];
		end
		a = hash_chain[0]; b = hash_chain[1]; c = hash_chain[2]; d = hash_chain[3];
		e = hash_chain[4]; f = hash_chain[5]; g = hash_chain[6]; h = hash_chain[7];
		for (int j = 0; j < 64; j++) begin
			a12 = rotl(a, 12);
			tj = (j < 16) ? ROUND_T_LO : ROUND_T_HI;
			ss1 = rotl(a12 + e + rotl(tj, j), 7);
			ss2 = ss1 ^ a12;
			if (j < 16) begin
				ff = a ^ b ^ c;
				gg = e ^ f ^ g;
			end else begin
				ff = (a & b) | (a & c) | (b & c);
				gg = (e & f) | (~e & g);
			end
			tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
			tt2 = gg + h + ss1 + w[j];
			d = c;
			c = rotl(b, 9);
			b = a;
			a = tt1;
			h = g;
			g = rotl(f, 19);
			f = e;
			e = mix0(tt2);
		end
		hash_chain[0] ^= a; hash_chain[1] ^= b; hash_chain[2] ^= c; hash_chain[3] ^= d;
		hash_chain[4] ^= e; hash_chain[5] ^= f; hash_chain[6] ^= g; hash_chain[7] ^= h;
	endtask

	task automatic load_block_word(word_t v);
		blk_buf[blk_fill] = v;
		blk_fill++;
		if (blk_fill == 16) begin
			compress_block();
			blk_fill = 0;
		end
	endtask

	task automatic hash_word(input word_t msg, input logic [2:0] nbytes, input logic last,
		output bit done, output state8_t digest);
		int unsigned n;
		word_t keep;
		done = 1'b0;
		digest = '0;
		if (!last) begin
			msg_bits += 64'd32;
			load_block_word(msg);
			return;
		end
		n = (nbytes > 4) ? 4 : nbytes;
		msg_bits += 64'(8 * n);
		if (n == 4) begin
			load_block_word(msg);
			load_block_word(MARKER_WORD);
		end else begin
			keep = (n == 0) ? 32'h0 : (32'hffffffff << (32 - 8 * n));
			load_block_word((msg & keep) | (MARKER_WORD >> (8 * n)));
		end
		if (blk_fill > 14) begin
			while (blk_fill != 0) begin
				load_block_word(32'h0);
			end
		end
		while (blk_fill < 14) begin
			load_block_word(32'h0);
		end
		load_block_word(msg_bits[63:32]);
		load_block_word(msg_bits[31:0]);
		done = 1'b1;
		digest = hash_chain;
		hash_chain = CHAIN_INIT;
		msg_bits = '0;
		blk_fill = 0;
	endtask

	function automatic void add_vector(word_t msg, logic [2:0] nbytes, logic last, bit known,
		state8_t digest);
		vector_row_t row;
		row.msg = msg;
		row.nbytes = nbytes;
		row.last = last;
		row.known = known;
		row.digest = digest;
		vector_tab.push_back(row);
	endfunction

	task automatic send_item(input word_t msg, input logic [2:0] nbytes, input logic last,
		input bit known, input state8_t known_digest);
		bit done;
		state8_t digest;
		digest_exp_t ex;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			msg_in.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		msg_in.valid <= 1'b1;
		msg_in.message_word <= msg;
		msg_in.byte_count <= nbytes;
		msg_in.last_word <= last;
		do begin
			@(posedge clk);
		end while (!msg_in.ready);
		hash_word(msg, nbytes, last, done, digest);
		if (done) begin
			if (known) begin
				digest = known_digest;
			end
			for (int k = 0; k < 8; k++) begin
				ex.digest_word = digest[k];
				ex.word_index = k[2:0];
				ex.final_word = (k == 7);
				digest_q.push_back(ex);
			end
		end
	endtask

	task automatic wait_drain();
		msg_in.valid <= 1'b0;
		while (digest_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		dig_out.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_on && $urandom_range(0, 5) == 0) begin
				dig_out.ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			dig_out.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		digest_exp_t ex;
		if (arst_n && dig_out.valid && dig_out.ready) begin
			if (digest_q.size() == 0) begin
				$error("digest transaction with none expected: word %h index %0d",
					dig_out.digest_word, dig_out.word_index);
				mismatches++;
			end else begin
				ex = digest_q.pop_front();
				if (dig_out.digest_word !== ex.digest_word) begin
					$error("digest_word expected %h actual %h", ex.digest_word,
						dig_out.digest_word);
					mismatches++;
				end
				if (dig_out.word_index !== ex.word_index) begin
					$error("word_index expected %0d actual %0d", ex.word_index,
						dig_out.word_index);
					mismatches++;
				end
				if (dig_out.final_word !== ex.final_word) begin
					$error("final_word expected %b actual %b", ex.final_word,
						dig_out.final_word);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((msg_in.valid && msg_in.ready) || (dig_out.valid && dig_out.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int unsigned items;
		int unsigned len;
		logic [2:0] nb;
		arst_n <= 1'b0;
		msg_in.valid <= 1'b0;
		msg_in.message_word <= '0;
		msg_in.byte_count <= '0;
		msg_in.last_word <= 1'b0;
		mismatches = 0;
		hash_chain = CHAIN_INIT;
		blk_fill = 0;
		msg_bits = '0;
		idle_on = 1'b1;
		stall_on = 1'b1;

		add_vector(32'h00000000, 3'd0, 1'b1, 1'b1, {
			32'h1ab21d83, 32'h55cfa17f, 32'h8e611948, 32'h31e81a8f,
			32'h22bec8c7, 32'h28fefb74, 32'h7ed035eb, 32'h5082aa2b});
		add_vector(32'h616263a5, 3'd3, 1'b1, 1'b1, {
			32'h66c7f0f4, 32'h62eeedd9, 32'hd1f2d46b, 32'hdc10e4e2,
			32'h4167c487, 32'h5cf2f7a2, 32'h297da02b, 32'h8f4ba8e0});
		for (int i = 0; i < 16; i++) begin
			nb = i[2:0];
			add_vector(32'h61626364, nb, 1'b0, 1'b0, '0);
		end
		add_vector(32'hffffffff, 3'd0, 1'b1, 1'b1, {
			32'hdebe9ff9, 32'h2275b8a1, 32'h38604889, 32'hc18e5a4d,
			32'h6fdb70e5, 32'h387e5765, 32'h293dcba3, 32'h9c0c5732});
		add_vector(32'hffffffff, 3'd4, 1'b1, 1'b0, '0);
		add_vector(32'h00000000, 3'd7, 1'b1, 1'b0, '0);
		add_vector(32'hffffffff, 3'd5, 1'b1, 1'b0, '0);
		add_vector(32'h80000000, 3'd1, 1'b1, 1'b0, '0);
		add_vector(32'h12345678, 3'd2, 1'b1, 1'b0, '0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (vector_tab[i]) begin
			send_item(vector_tab[i].msg, vector_tab[i].nbytes, vector_tab[i].last,
				vector_tab[i].known, vector_tab[i].digest);
		end
		wait_drain();

		items = 0;
		while (items < RANDOM_ITEMS) begin
			if (items >= QUIET_ITEMS) begin
				idle_on = 1'b0;
				stall_on = 1'b0;
			end else begin
				idle_on = ($urandom_range(0, 3) != 0);
				stall_on = ($urandom_range(0, 3) != 0);
			end
			case ($urandom_range(0, 3))
				0: begin
					len = $urandom_range(0, 3);
				end
				1: begin
					len = $urandom_range(12, 17);
				end
				2: begin
					len = $urandom_range(28, 33);
				end
				default: begin
					len = $urandom_range(0, 12);
				end
			endcase
			repeat (len) begin
				send_item($urandom, 3'($urandom_range(0, 7)), 1'b0, 1'b0, '0);
				items++;
			end
			send_item($urandom, 3'($urandom_range(0, 7)), 1'b1, 1'b0, '0);
			items++;
			if (items < QUIET_ITEMS && $urandom_range(0, 7) == 0) begin
				wait_drain();
			end
		end
		wait_drain();

		if (mismatches == 0 && digest_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire
